[rtl/core/rgb_to_hsv_pixel_unit_assert.svh]
// Assertion macros for the pixel unit.
`ifndef RGB_TO_HSV_PIXEL_UNIT_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define RGBHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RGBHSV_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBHSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define RGBHSV_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/rgbhsv_pkg.sv]
package rgbhsv_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_FRAC_BITS = 12;

    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 13;
    localparam int VAL_W = 8;

    // quotient bits each lane needs: hue < 360 * 2^HUE_FRAC_BITS, sat <= 2^SAT_FRAC_BITS
    localparam int HUE_Q_W = 9 + HUE_FRAC_BITS;
    localparam int SAT_Q_W = SAT_FRAC_BITS + 1;
    localparam int N_CELLS = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
    // dividend is below divisor * 2^N_CELLS, divisor fits a channel byte
    localparam int DVD_W = N_CELLS + CH_W;
    // unscaled hue numerator stays below 360 * 255
    localparam int NUM_W = 17;

    typedef enum logic [2:0] {
        SEC_BLUE  = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_RED   = 3'b100
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [VAL_W-1:0] value;
    } t_hsv;

    // one restoring-division lane in flight
    typedef struct packed {
        logic [CH_W-1:0]    rem;
        logic [N_CELLS-1:0] low;
        logic [CH_W-1:0]    dvs;
        logic [N_CELLS-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane           sat;
        t_lane           hue;
        logic [CH_W-1:0] value;
    } t_div_data;

endpackage

[rtl/core/rgbhsv_if.sv]
interface rgbhsv_pix_if;
    logic                valid;
    logic                ready;
    rgbhsv_pkg::t_pixel  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rgbhsv_hsv_if;
    logic              valid;
    logic              ready;
    rgbhsv_pkg::t_hsv  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rgbhsv_front.sv]
module rgbhsv_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  rgbhsv_pkg::t_pixel     i_pixel,
    output logic                   o_valid,
    input  logic                   i_ready,
    output rgbhsv_pkg::t_div_data  o_data
);

    typedef struct packed {
        logic [rgbhsv_pkg::CH_W-1:0] mx;
        logic [rgbhsv_pkg::CH_W-1:0] mn;
        rgbhsv_pkg::t_sector         sector;
        logic [rgbhsv_pkg::CH_W-1:0] blue;
        logic [rgbhsv_pkg::CH_W-1:0] green;
        logic [rgbhsv_pkg::CH_W-1:0] red;
    } t_extrema;

    logic                  r_v1;
    logic                  r_v2;
    logic                  rdy1;
    logic                  rdy2;
    t_extrema              r_s1;
    t_extrema              n_s1;
    rgbhsv_pkg::t_div_data r_s2;
    rgbhsv_pkg::t_div_data n_s2;

    logic [rgbhsv_pkg::CH_W-1:0]  delta;
    logic [rgbhsv_pkg::CH_W+2:0]  offs_d;
    logic signed [8:0]            diff;
    logic signed [11:0]           sum;
    logic signed [17:0]           num60;
    logic [rgbhsv_pkg::NUM_W-1:0] wrap;
    logic [17:0]                  wrapped;
    logic [rgbhsv_pkg::NUM_W-1:0] num_u;
    logic [rgbhsv_pkg::DVD_W-1:0] hue_n;
    logic [rgbhsv_pkg::DVD_W-1:0] sat_n;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    // first largest in blue, green, red order; ties stay with the earlier channel
    always_comb begin
        n_s1.mx     = i_pixel.blue;
        n_s1.mn     = i_pixel.blue;
        n_s1.sector = rgbhsv_pkg::SEC_BLUE;
        if (i_pixel.green > n_s1.mx) begin
            n_s1.mx     = i_pixel.green;
            n_s1.sector = rgbhsv_pkg::SEC_GREEN;
        end
        if (i_pixel.red > n_s1.mx) begin
            n_s1.mx     = i_pixel.red;
            n_s1.sector = rgbhsv_pkg::SEC_RED;
        end
        if (i_pixel.green < n_s1.mn) begin
            n_s1.mn = i_pixel.green;
        end
        if (i_pixel.red < n_s1.mn) begin
            n_s1.mn = i_pixel.red;
        end
        n_s1.blue  = i_pixel.blue;
        n_s1.green = i_pixel.green;
        n_s1.red   = i_pixel.red;
    end

    always_comb begin
        delta = r_s1.mx - r_s1.mn;
        case (r_s1.sector)
            rgbhsv_pkg::SEC_RED: begin
                offs_d = '0;
                diff   = $signed({1'b0, r_s1.green}) - $signed({1'b0, r_s1.blue});
            end
            rgbhsv_pkg::SEC_GREEN: begin
                offs_d = {2'b00, delta, 1'b0};
                diff   = $signed({1'b0, r_s1.blue}) - $signed({1'b0, r_s1.red});
            end
            default: begin
                offs_d = {1'b0, delta, 2'b00};
                diff   = $signed({1'b0, r_s1.red}) - $signed({1'b0, r_s1.green});
            end
        endcase
        sum     = $signed({1'b0, offs_d}) + $signed({{3{diff[8]}}, diff});
        num60   = $signed({{6{sum[11]}}, sum}) * 18'sd60;
        wrap    = rgbhsv_pkg::NUM_W'(delta) * rgbhsv_pkg::NUM_W'(360);
        // negative hue wraps by a full turn
        wrapped = num60 + $signed({1'b0, wrap});
        if (num60[17]) begin
            num_u = wrapped[rgbhsv_pkg::NUM_W-1:0];
        end else begin
            num_u = num60[rgbhsv_pkg::NUM_W-1:0];
        end

        hue_n = rgbhsv_pkg::DVD_W'(num_u) << rgbhsv_pkg::HUE_FRAC_BITS;
        sat_n = rgbhsv_pkg::DVD_W'(delta) << rgbhsv_pkg::SAT_FRAC_BITS;
        n_s2.hue.dvs = delta;
        n_s2.sat.dvs = r_s1.mx;
        // gray or black: zero dividend over divisor one gives a zero quotient
        if (delta == '0) begin
            hue_n        = '0;
            n_s2.hue.dvs = rgbhsv_pkg::CH_W'(1);
        end
        if (r_s1.mx == '0) begin
            n_s2.sat.dvs = rgbhsv_pkg::CH_W'(1);
        end

        n_s2.hue.rem = hue_n[rgbhsv_pkg::DVD_W-1 -: rgbhsv_pkg::CH_W];
        n_s2.hue.low = hue_n[rgbhsv_pkg::N_CELLS-1:0];
        n_s2.hue.quo = '0;
        n_s2.sat.rem = sat_n[rgbhsv_pkg::DVD_W-1 -: rgbhsv_pkg::CH_W];
        n_s2.sat.low = sat_n[rgbhsv_pkg::N_CELLS-1:0];
        n_s2.sat.quo = '0;
        n_s2.value   = r_s1.mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

endmodule

[rtl/core/rgbhsv_div_cell.sv]
module rgbhsv_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  rgbhsv_pkg::t_div_data  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output rgbhsv_pkg::t_div_data  o_data
);

    logic                  r_valid;
    rgbhsv_pkg::t_div_data r_data;
    rgbhsv_pkg::t_div_data n_data;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic rgbhsv_pkg::t_lane div_step(input rgbhsv_pkg::t_lane lane);
        rgbhsv_pkg::t_lane         res;
        logic [rgbhsv_pkg::CH_W:0] trial;
        logic [rgbhsv_pkg::CH_W:0] dvs_x;
        logic [rgbhsv_pkg::CH_W:0] rest;
        res      = lane;
        trial    = {lane.rem, lane.low[rgbhsv_pkg::N_CELLS-1]};
        dvs_x    = {1'b0, lane.dvs};
        rest     = trial - dvs_x;
        res.low  = {lane.low[rgbhsv_pkg::N_CELLS-2:0], 1'b0};
        if (trial >= dvs_x) begin
            res.rem = rest[rgbhsv_pkg::CH_W-1:0];
            res.quo = {lane.quo[rgbhsv_pkg::N_CELLS-2:0], 1'b1};
        end else begin
            res.rem = trial[rgbhsv_pkg::CH_W-1:0];
            res.quo = {lane.quo[rgbhsv_pkg::N_CELLS-2:0], 1'b0};
        end
        return res;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.sat   = div_step(i_data.sat);
        n_data.hue   = div_step(i_data.hue);
        n_data.value = i_data.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[rtl/core/rgb_to_hsv_pixel_unit.sv]
// From an accepted pixel to its result on o_hsv: two front stages for extrema and hue
// numerator, then 15 division cells, one quotient bit each.
// Throughput: one pixel per cycle while o_hsv is ready; each stage holds its request only while downstream stalls.
// Reset (synchronous, active low) clears every stage valid flag and drops pixels in flight.
`include "rgb_to_hsv_pixel_unit_assert.svh"

module rgb_to_hsv_pixel_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsv_pix_if.sink    i_pix,
    rgbhsv_hsv_if.source  o_hsv
);

    logic                  cell_valid [rgbhsv_pkg::N_CELLS+1];
    logic                  cell_ready [rgbhsv_pkg::N_CELLS+1];
    rgbhsv_pkg::t_div_data cell_data  [rgbhsv_pkg::N_CELLS+1];

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_pixel (i_pix.data),
        .o_valid (cell_valid[0]),
        .i_ready (cell_ready[0]),
        .o_data  (cell_data[0])
    );

    for (genvar k = 0; k < rgbhsv_pkg::N_CELLS; k++) begin : g_cell
        rgbhsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .o_ready (cell_ready[k]),
            .i_data  (cell_data[k]),
            .o_valid (cell_valid[k+1]),
            .i_ready (cell_ready[k+1]),
            .o_data  (cell_data[k+1])
        );
    end

    // last cell register is the output register
    assign cell_ready[rgbhsv_pkg::N_CELLS] = o_hsv.ready;
    assign o_hsv.valid = cell_valid[rgbhsv_pkg::N_CELLS];
    assign o_hsv.data.hue =
        (rgbhsv_pkg::HUE_W)'(cell_data[rgbhsv_pkg::N_CELLS].hue.quo);
    assign o_hsv.data.saturation =
        (rgbhsv_pkg::SAT_W)'(cell_data[rgbhsv_pkg::N_CELLS].sat.quo);
    assign o_hsv.data.value = cell_data[rgbhsv_pkg::N_CELLS].value;

    `RGBHSV_ASSERT_ANY(a_rst_no_result, i_clk, !$past(i_rst_n) |-> !o_hsv.valid, "result after reset")
    `RGBHSV_ASSERT_ANY(a_rst_ready, i_clk, !$past(i_rst_n) |-> i_pix.ready, "not ready after reset")
    `RGBHSV_ASSERT(a_black_zero, i_clk, i_rst_n, o_hsv.valid && (o_hsv.data.value == '0) |-> (o_hsv.data.saturation == '0) && (o_hsv.data.hue == '0), "black pixel with hue or saturation")

endmodule

[tb/testbench.sv]
class hsv_result_book;
    rgbhsv_pkg::t_hsv pending_hsv[$];
    int               mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    // Exact integer conversion; the sector is the first largest of blue, green, red.
    function rgbhsv_pkg::t_hsv convert_pixel(rgbhsv_pkg::t_pixel px);
        rgbhsv_pkg::t_sector sector;
        longint              b, g, r, top, bottom, delta, offset, diff, num;
        logic [63:0]         hue_full, sat_full;
        rgbhsv_pkg::t_hsv    res;
        b = px.blue;
        g = px.green;
        r = px.red;
        top = b;
        bottom = b;
        sector = rgbhsv_pkg::SEC_BLUE;
        if (g > top) begin
            top = g;
            sector = rgbhsv_pkg::SEC_GREEN;
        end
        if (r > top) begin
            top = r;
            sector = rgbhsv_pkg::SEC_RED;
        end
        if (g < bottom) bottom = g;
        if (r < bottom) bottom = r;
        delta = top - bottom;
        sat_full = '0;
        hue_full = '0;
        if (top > 0) sat_full = (delta << rgbhsv_pkg::SAT_FRAC_BITS) / top;
        if (delta > 0) begin
            case (sector)
                rgbhsv_pkg::SEC_RED: begin
                    offset = 0;
                    diff = g - b;
                end
                rgbhsv_pkg::SEC_GREEN: begin
                    offset = 2;
                    diff = b - r;
                end
                default: begin
                    offset = 4;
                    diff = r - g;
                end
            endcase
            num = 60 * (offset * delta + diff);
            // wrap negative hue by a full turn
            if (num < 0) num += 360 * delta;
            hue_full = (num << rgbhsv_pkg::HUE_FRAC_BITS) / delta;
        end
        res.hue = hue_full[rgbhsv_pkg::HUE_W-1:0];
        res.saturation = sat_full[rgbhsv_pkg::SAT_W-1:0];
        res.value = top[rgbhsv_pkg::VAL_W-1:0];
        return res;
    endfunction

    function void note_pixel(rgbhsv_pkg::t_pixel px);
        pending_hsv.push_back(convert_pixel(px));
    endfunction

    function void check_hsv(rgbhsv_pkg::t_hsv got);
        rgbhsv_pkg::t_hsv want;
        if (pending_hsv.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected hsv result: hue %0d sat %0d value %0d",
                         got.hue, got.saturation, got.value);
            return;
        end
        want = pending_hsv.pop_front();
        if (got.hue !== want.hue || got.saturation !== want.saturation ||
            got.value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"hsv mismatch: expected hue %0d sat %0d value %0d, ",
                          "got hue %0d sat %0d value %0d"},
                         want.hue, want.saturation, want.value,
                         got.hue, got.saturation, got.value);
        end
    endfunction
endclass

module testbench;
    logic i_clk;
    logic i_rst_n;

    rgbhsv_pix_if pix_bus ();
    rgbhsv_hsv_if hsv_bus ();

    hsv_result_book book = new();
    bit idle_on;
    int stall_cycles;

    rgb_to_hsv_pixel_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_hsv   (hsv_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 200000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic rgbhsv_pkg::t_pixel random_pixel();
        rgbhsv_pkg::t_pixel px;
        px.blue = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.red = 8'($urandom_range(255));
        case ($urandom_range(9))
            0: begin
                px.green = px.blue;
                px.red = px.blue;
            end
            1: px.green = px.blue;
            2: px.red = px.green;
            3: px.red = px.blue;
            4: begin
                px.blue = 8'($urandom_range(3));
                px.green = 8'($urandom_range(3));
                px.red = 8'($urandom_range(3));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Offer one request; hold it until accepted.
    task automatic send_pixel(input rgbhsv_pkg::t_pixel px);
        while (idle_on && $urandom_range(99) < 8) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.data <= px;
        do @(posedge i_clk); while (!pix_bus.ready);
        book.note_pixel(px);
    endtask

    initial begin : hsv_sink
        hsv_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hsv_bus.valid && hsv_bus.ready) book.check_hsv(hsv_bus.data);
            if (stall_cycles > 0) begin
                hsv_bus.ready <= 1'b0;
                stall_cycles--;
            end else begin
                hsv_bus.ready <= !(idle_on && $urandom_range(99) < 8);
            end
        end
    end

    initial begin : pix_source
        int k;
        i_rst_n <= 1'b0;
        pix_bus.valid <= 1'b0;
        pix_bus.data <= '0;
        idle_on = 1'b1;
        stall_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, white, gray
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd0, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd255, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd128, 8'd128, 8'd128});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd1, 8'd1, 8'd1});
        // pure primaries at full and minimal scale
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd0, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd255, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd0, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd1, 8'd0, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd1, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd0, 8'd1});
        // ties for the largest channel
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd255, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd255, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd0, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd200, 8'd200, 8'd200 - 8'd1});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd7, 8'd9, 8'd9});
        // red sector with negative hue that wraps, and near the wrap point
        send_pixel(rgbhsv_pkg::t_pixel'{8'd1, 8'd0, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd254, 8'd0, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd1, 8'd255});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd254, 8'd255});
        // green and blue sector edges
        send_pixel(rgbhsv_pkg::t_pixel'{8'd254, 8'd255, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd0, 8'd255, 8'd254});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd254, 8'd0});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd255, 8'd0, 8'd254});
        send_pixel(rgbhsv_pkg::t_pixel'{8'd170, 8'd85, 8'd1});

        for (k = 0; k < 1150; k++) begin
            // long receiver hold-off while requests keep coming
            if (k == 100) stall_cycles = 250;
            if (k == 400) idle_on = 1'b0;
            if (k == 700) begin
                idle_on = 1'b1;
                pix_bus.valid <= 1'b0;
                do @(posedge i_clk); while (book.pending_hsv.size() != 0);
            end
            send_pixel(random_pixel());
        end
        pix_bus.valid <= 1'b0;

        while (book.pending_hsv.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (book.mismatch_count == 0 && book.pending_hsv.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[rgb_to_hsv_pixel_unit.f]
+incdir+rtl/core
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_if.sv
rtl/core/rgbhsv_front.sv
rtl/core/rgbhsv_div_cell.sv
rtl/core/rgb_to_hsv_pixel_unit.sv
tb/testbench.sv
